>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, ignored while reset is held
`define FPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, also across reset
`define FPP_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/fpp_pkg.sv
// types, constants and tables for the frustum picture placement block
package fpp_pkg;

    localparam int OUT_FRAC_BITS = 15;
    localparam int OUT_W         = 16;
    localparam logic [OUT_W-1:0] FRAC_ONE = OUT_W'(1) << OUT_FRAC_BITS;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_W        = 24;
    localparam int XY_W         = 32;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sh1000_0000;

    localparam int DIV_STAGES = 24;
    localparam int QUO_W      = 24;
    localparam int NUM_W      = 48;
    localparam int DEN_W      = 32;
    localparam int PROD_W     = 40;
    localparam int EDGE_W     = 28;
    localparam int NUM_LANES  = 8;

    localparam logic [QUO_W-1:0] TAN_MAX    = '1;
    localparam logic [15:0]      ANGLE_LOW  = 16'd256;
    localparam logic [15:0]      ANGLE_HIGH = 16'd45824;

    // atan(2^-i) in q16 degrees
    function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [3:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            4'd0:    v = 24'sd2949120;
            4'd1:    v = 24'sd1740967;
            4'd2:    v = 24'sd919879;
            4'd3:    v = 24'sd466945;
            4'd4:    v = 24'sd234379;
            4'd5:    v = 24'sd117304;
            4'd6:    v = 24'sd58666;
            4'd7:    v = 24'sd29335;
            4'd8:    v = 24'sd14668;
            4'd9:    v = 24'sd7334;
            4'd10:   v = 24'sd3667;
            4'd11:   v = 24'sd1833;
            4'd12:   v = 24'sd917;
            4'd13:   v = 24'sd458;
            4'd14:   v = 24'sd229;
            4'd15:   v = 24'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [15:0] eye_left;
        logic signed [15:0] eye_right;
        logic signed [15:0] eye_top;
        logic signed [15:0] eye_bottom;
        logic [15:0]        view_angle;
        logic [15:0]        frame_width;
        logic [15:0]        frame_height;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] dest_u_low;
        logic [OUT_W-1:0] dest_u_high;
        logic [OUT_W-1:0] dest_v_low;
        logic [OUT_W-1:0] dest_v_high;
        logic [OUT_W-1:0] src_u_low;
        logic [OUT_W-1:0] src_u_high;
        logic [OUT_W-1:0] src_v_low;
        logic [OUT_W-1:0] src_v_high;
        logic             cropped;
    } t_out_beat;

    typedef struct packed {
        t_in_beat         item;
        logic             mode;
        logic             ok;
        logic [QUO_W-1:0] tw;
        logic [QUO_W-1:0] th;
    } t_ctx;

    typedef struct packed {
        t_ctx ctx;
        logic zero;
        logic maxed;
    } t_tan_side;

    typedef struct packed {
        t_ctx ctx;
        logic sat;
    } t_asp_side;

    typedef enum logic [1:0] {
        LANE_ZERO,
        LANE_ONE,
        LANE_DIV
    } t_lane_sel;

    typedef struct packed {
        t_lane_sel [NUM_LANES-1:0] sel;
        logic                      cropped;
    } t_frac_side;

endpackage

>>> hdl/fpp_div.sv
// pipelined restoring divider, one quotient bit per stage
module fpp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fpp_pkg::NUM_W-1:0]   i_num,
    input  logic [fpp_pkg::DEN_W-1:0]   i_den,
    output logic [fpp_pkg::QUO_W-1:0]   o_quo
);
    import fpp_pkg::*;

    localparam int SH_W = DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    logic [NUM_W-1:0] s_rem [DIV_STAGES];
    logic [DEN_W-1:0] s_den [DIV_STAGES];
    logic [QUO_W-1:0] s_quo [DIV_STAGES];
    logic [NUM_W-1:0] n_rem [DIV_STAGES];
    logic [QUO_W-1:0] n_quo [DIV_STAGES];

    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;

    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_link
        assign s_rem[s] = r_rem[s-1];
        assign s_den[s] = r_den[s-1];
        assign s_quo[s] = r_quo[s-1];
    end

    // stage s settles quotient bit QUO_W-1-s
    always_comb begin
        logic [SH_W-1:0] dsh;
        for (int s = 0; s < DIV_STAGES; s++) begin
            dsh = SH_W'(s_den[s]) << (QUO_W - 1 - s);
            if ({{(SH_W-NUM_W){1'b0}}, s_rem[s]} >= dsh) begin
                n_rem[s] = s_rem[s] - NUM_W'(dsh);
                n_quo[s] = s_quo[s] | (QUO_W'(1) << (QUO_W - 1 - s));
            end else begin
                n_rem[s] = s_rem[s];
                n_quo[s] = s_quo[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= s_den[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

>>> hdl/frustum_picture_placement.sv
// frustum picture placement: top level, full datapath pipeline
// One frustum beat in, one placement beat out, a new beat every cycle.
// Its stages, in order: input register, 16 cordic stages for tan of the half
// angle, a 24-stage divider for y/x, two stages for the 4:3 scale and the
// aspect product, a second 24-stage divider for the aspect ratio, the tangent
// register, the edge-fraction register, eight parallel 24-stage dividers for
// the fractions and the output register. The whole pipe moves
// together; it holds only while a finished beat sits in the output register
// and the sink is not ready, so in_ready is low exactly then. The 4:3 mode
// register is sampled as each beat enters. Degenerate frames, angles,
// tangents or eye frusta give the full-texture placement with cropped low.
`include "assert_macros.svh"

module frustum_picture_placement (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fpp_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpp_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import fpp_pkg::*;

    // pipe advance: everything moves unless the output beat is stuck
    logic en;
    logic r_mode;
    logic r_out_vld;
    t_out_beat r_out;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // ---------------- input register ----------------
    logic r_in_vld;
    t_ctx r_in_ctx;
    t_ctx n_in_ctx;

    always_comb begin
        n_in_ctx      = '0;
        n_in_ctx.item = i_in_beat;
        n_in_ctx.mode = r_mode;
        // frame present and angle strictly inside 1..179 degrees
        n_in_ctx.ok   = (i_in_beat.frame_width != '0) && (i_in_beat.frame_height != '0)
                     && (i_in_beat.view_angle > ANGLE_LOW)
                     && (i_in_beat.view_angle < ANGLE_HIGH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_ctx <= n_in_ctx;
        end
    end

    // ---------------- cordic rotation, one step per stage ----------------
    logic signed [XY_W-1:0]  r_cx [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_cy [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_cz [CORDIC_STEPS];
    t_ctx                    r_cctx [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] r_cvld;

    logic signed [XY_W-1:0]  c_x [CORDIC_STEPS];
    logic signed [XY_W-1:0]  c_y [CORDIC_STEPS];
    logic signed [ANG_W-1:0] c_z [CORDIC_STEPS];
    t_ctx                    c_ctx [CORDIC_STEPS];
    logic signed [XY_W-1:0]  n_cx [CORDIC_STEPS];
    logic signed [XY_W-1:0]  n_cy [CORDIC_STEPS];
    logic signed [ANG_W-1:0] n_cz [CORDIC_STEPS];

    // half angle in q16 degrees is the q8.8 angle shifted up by seven
    assign c_x[0]   = CORDIC_X0;
    assign c_y[0]   = '0;
    assign c_z[0]   = ANG_W'({r_in_ctx.item.view_angle, 7'b0});
    assign c_ctx[0] = r_in_ctx;

    for (genvar k = 1; k < CORDIC_STEPS; k++) begin : g_cordic_link
        assign c_x[k]   = r_cx[k-1];
        assign c_y[k]   = r_cy[k-1];
        assign c_z[k]   = r_cz[k-1];
        assign c_ctx[k] = r_cctx[k-1];
    end

    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = c_y[k] >>> k;
            dy = c_x[k] >>> k;
            if (c_z[k] >= 0) begin
                n_cx[k] = c_x[k] - dx;
                n_cy[k] = c_y[k] + dy;
                n_cz[k] = c_z[k] - cordic_atan(4'(k));
            end else begin
                n_cx[k] = c_x[k] + dx;
                n_cy[k] = c_y[k] - dy;
                n_cz[k] = c_z[k] + cordic_atan(4'(k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (en) begin
            r_cvld <= {r_cvld[CORDIC_STEPS-2:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cx[k]   <= n_cx[k];
                r_cy[k]   <= n_cy[k];
                r_cz[k]   <= n_cz[k];
                r_cctx[k] <= c_ctx[k];
            end
        end
    end

    // ---------------- tan = (y << 16) / x ----------------
    logic signed [XY_W-1:0] cx_last;
    logic signed [XY_W-1:0] cy_last;
    logic signed [39:0]     cy_ext;
    logic signed [39:0]     cx_sh;
    logic [NUM_W-1:0]       tan_num;
    logic [DEN_W-1:0]       tan_den;
    logic [QUO_W-1:0]       tan_quo;
    t_tan_side              n_tside;
    t_tan_side              r_tside [DIV_STAGES];
    logic [DIV_STAGES-1:0]  r_tvld;

    assign cx_last = r_cx[CORDIC_STEPS-1];
    assign cy_last = r_cy[CORDIC_STEPS-1];
    assign cy_ext  = 40'(cy_last);
    assign cx_sh   = 40'(cx_last) <<< 8;
    assign tan_num = NUM_W'($unsigned(cy_last)) << 16;
    assign tan_den = DEN_W'($unsigned(cx_last));

    // y not positive gives zero; x not positive or quotient past 24 bits saturates
    always_comb begin
        n_tside.ctx   = r_cctx[CORDIC_STEPS-1];
        n_tside.zero  = (cy_last <= 0);
        n_tside.maxed = (cx_last <= 0) || (cy_ext >= cx_sh);
    end

    fpp_div u_tan_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (tan_num),
        .i_den (tan_den),
        .o_quo (tan_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld <= '0;
        end else if (en) begin
            r_tvld <= {r_tvld[DIV_STAGES-2:0], r_cvld[CORDIC_STEPS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tside[0] <= n_tside;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_tside[s] <= r_tside[s-1];
            end
        end
    end

    // ---------------- 4:3 scale and operand select ----------------
    t_tan_side        t_last;
    logic [QUO_W-1:0] t_q;
    logic [QUO_W+1:0] t_x3;
    logic [QUO_W-1:0] th43;
    t_ctx             n_a_ctx;
    logic [QUO_W-1:0] n_a_mul;
    logic [15:0]      n_a_fac;
    logic [15:0]      n_a_den;

    logic             r_a_vld;
    t_ctx             r_a_ctx;
    logic [QUO_W-1:0] r_a_mul;
    logic [15:0]      r_a_fac;
    logic [15:0]      r_a_den;

    assign t_last = r_tside[DIV_STAGES-1];
    assign t_q    = t_last.zero ? '0 : (t_last.maxed ? TAN_MAX : tan_quo);
    assign t_x3   = (QUO_W+2)'(t_q) + {1'b0, t_q, 1'b0};
    assign th43   = QUO_W'(t_x3 >> 2);

    always_comb begin
        n_a_ctx = t_last.ctx;
        if (t_last.ctx.mode) begin
            // vertical held: th = 3t/4, tw follows from th * w / h
            n_a_ctx.th = th43;
            n_a_mul    = th43;
            n_a_fac    = t_last.ctx.item.frame_width;
            n_a_den    = t_last.ctx.item.frame_height;
        end else begin
            // horizontal angle: tw = t, th follows from tw * h / w
            n_a_ctx.tw = t_q;
            n_a_mul    = t_q;
            n_a_fac    = t_last.ctx.item.frame_height;
            n_a_den    = t_last.ctx.item.frame_width;
        end
    end

    // ---------------- aspect product ----------------
    logic              r_b_vld;
    t_ctx              r_b_ctx;
    logic [PROD_W-1:0] r_b_prod;
    logic [15:0]       r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= r_tvld[DIV_STAGES-1];
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctx  <= n_a_ctx;
            r_a_mul  <= n_a_mul;
            r_a_fac  <= n_a_fac;
            r_a_den  <= n_a_den;
            r_b_ctx  <= r_a_ctx;
            r_b_prod <= PROD_W'(r_a_mul) * PROD_W'(r_a_fac);
            r_b_den  <= r_a_den;
        end
    end

    // ---------------- aspect division ----------------
    logic [QUO_W-1:0]      asp_quo;
    t_asp_side             n_sside;
    t_asp_side             r_sside [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_svld;

    always_comb begin
        n_sside.ctx = r_b_ctx;
        n_sside.sat = (r_b_prod >= {r_b_den, {QUO_W{1'b0}}});
    end

    fpp_div u_asp_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'(r_b_prod)),
        .i_den (DEN_W'(r_b_den)),
        .o_quo (asp_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= '0;
        end else if (en) begin
            r_svld <= {r_svld[DIV_STAGES-2:0], r_b_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sside[0] <= n_sside;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_sside[s] <= r_sside[s-1];
            end
        end
    end

    // ---------------- final tangents ----------------
    t_asp_side        s_last;
    logic [QUO_W-1:0] asp_q;
    t_ctx             n_c_ctx;
    logic             r_c_vld;
    t_ctx             r_c_ctx;

    assign s_last = r_sside[DIV_STAGES-1];
    assign asp_q  = s_last.sat ? TAN_MAX : asp_quo;

    always_comb begin
        n_c_ctx = s_last.ctx;
        if (s_last.ctx.mode) begin
            n_c_ctx.tw = asp_q;
        end else begin
            n_c_ctx.th = asp_q;
        end
    end

    // ---------------- edge fractions: numerators, denominators, lane codes ----------------
    logic signed [EDGE_W-1:0] e_l;
    logic signed [EDGE_W-1:0] e_r;
    logic signed [EDGE_W-1:0] e_t;
    logic signed [EDGE_W-1:0] e_b;
    logic signed [EDGE_W-1:0] e_tw;
    logic signed [EDGE_W-1:0] e_th;
    logic signed [EDGE_W-1:0] e_ew;
    logic signed [EDGE_W-1:0] e_eh;
    logic signed [EDGE_W-1:0] p_num [NUM_LANES];
    logic signed [EDGE_W-1:0] p_den [NUM_LANES];
    logic [NUM_LANES-1:0]     p_act;
    logic [NUM_LANES-1:0]     p_hi;
    logic                     good;
    logic [3:0]               clip;
    t_frac_side               n_pside;

    always_comb begin
        // tangents q3.12 to the q16 of the picture tangents
        e_l  = EDGE_W'(r_c_ctx.item.eye_left) <<< 4;
        e_r  = EDGE_W'(r_c_ctx.item.eye_right) <<< 4;
        e_t  = EDGE_W'(r_c_ctx.item.eye_top) <<< 4;
        e_b  = EDGE_W'(r_c_ctx.item.eye_bottom) <<< 4;
        e_tw = EDGE_W'(r_c_ctx.tw);
        e_th = EDGE_W'(r_c_ctx.th);
        e_ew = e_r - e_l;
        e_eh = e_b - e_t;
        good = r_c_ctx.ok && (r_c_ctx.tw != '0) && (r_c_ctx.th != '0)
            && (e_ew > 0) && (e_eh > 0);

        // destination edges over the eye span
        p_num[0] = -e_l - e_tw;  p_den[0] = e_ew;
        p_num[1] = -e_l + e_tw;  p_den[1] = e_ew;
        p_num[2] = e_b - e_th;   p_den[2] = e_eh;
        p_num[3] = e_b + e_th;   p_den[3] = e_eh;
        // kept source share over the picture span
        p_num[4] = e_l + e_tw;   p_den[4] = e_tw <<< 1;
        p_num[5] = e_tw + e_r;   p_den[5] = e_tw <<< 1;
        p_num[6] = e_th - e_b;   p_den[6] = e_th <<< 1;
        p_num[7] = e_th - e_t;   p_den[7] = e_th <<< 1;

        clip[0] = (p_num[0] < 0);
        clip[1] = (p_num[1] > e_ew);
        clip[2] = (p_num[2] < 0);
        clip[3] = (p_num[3] > e_eh);

        p_act = {good & clip[3], good & clip[2], good & clip[1], good & clip[0],
                 {4{good}}};
        p_hi  = 8'b1010_1010;

        for (int l = 0; l < NUM_LANES; l++) begin
            if (!p_act[l]) begin
                n_pside.sel[l] = p_hi[l] ? LANE_ONE : LANE_ZERO;
            end else if (p_num[l] <= 0) begin
                n_pside.sel[l] = LANE_ZERO;
            end else if (p_num[l] >= p_den[l]) begin
                n_pside.sel[l] = LANE_ONE;
            end else begin
                n_pside.sel[l] = LANE_DIV;
            end
        end
        n_pside.cropped = good && (clip != '0);
    end

    logic             r_p_vld;
    logic [NUM_W-1:0] r_p_num [NUM_LANES];
    logic [DEN_W-1:0] r_p_den [NUM_LANES];
    t_frac_side       r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_svld[DIV_STAGES-1];
            r_p_vld <= r_c_vld;
        end
    end

    // rounded fraction: ((num << 16) + den) / (2 * den)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ctx  <= n_c_ctx;
            r_p_side <= n_pside;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_p_num[l] <= (NUM_W'($unsigned(p_num[l])) << (OUT_FRAC_BITS + 1))
                            + NUM_W'($unsigned(p_den[l]));
                r_p_den[l] <= DEN_W'($unsigned(p_den[l])) << 1;
            end
        end
    end

    // ---------------- eight fraction dividers ----------------
    logic [QUO_W-1:0]      f_quo [NUM_LANES];
    t_frac_side            r_fside [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_fvld;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_frac
        fpp_div u_frac_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_p_num[l]),
            .i_den (r_p_den[l]),
            .o_quo (f_quo[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else if (en) begin
            r_fvld <= {r_fvld[DIV_STAGES-2:0], r_p_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fside[0] <= r_p_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_fside[s] <= r_fside[s-1];
            end
        end
    end

    // ---------------- output register ----------------
    t_frac_side       f_last;
    logic [OUT_W-1:0] f_val [NUM_LANES];
    t_out_beat        n_out;

    assign f_last = r_fside[DIV_STAGES-1];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            case (f_last.sel[l])
                LANE_ZERO: f_val[l] = '0;
                LANE_ONE:  f_val[l] = FRAC_ONE;
                LANE_DIV:  f_val[l] = OUT_W'(f_quo[l]);
                default:   f_val[l] = '0;
            endcase
        end
        n_out.dest_u_low  = f_val[0];
        n_out.dest_u_high = f_val[1];
        n_out.dest_v_low  = f_val[2];
        n_out.dest_v_high = f_val[3];
        n_out.src_u_low   = f_val[4];
        n_out.src_u_high  = f_val[5];
        n_out.src_v_low   = f_val[6];
        n_out.src_v_high  = f_val[7];
        n_out.cropped     = f_last.cropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_fvld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // ---------------- checks ----------------
    logic chk_dest_order;
    logic chk_frac_range;

    assign chk_dest_order = (o_out_beat.dest_u_low <= o_out_beat.dest_u_high)
                         && (o_out_beat.dest_v_low <= o_out_beat.dest_v_high);
    assign chk_frac_range = (o_out_beat.dest_u_high <= FRAC_ONE)
                         && (o_out_beat.src_v_high <= FRAC_ONE);

    `FPP_ASSERT(a_dest_order, o_out_valid |-> chk_dest_order, "dest edges out of order")
    `FPP_ASSERT(a_frac_range, o_out_valid |-> chk_frac_range, "fraction above one")
    `FPP_ASSERT_NR(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

>>> bench/tb_frustum_picture_placement.sv
// testbench for the frustum picture placement block, self-checking with its own predictor
`timescale 1ns / 1ps

module tb_frustum_picture_placement;
    import fpp_pkg::*;

    localparam int LATENCY   = 94;
    localparam int ONE_Q15   = 1 << 15;
    localparam int ANG_MIN   = 256;
    localparam int ANG_MAX   = 45824;

    // atan(2^-i) in q16 degrees, the rotation table of the tangent engine
    localparam longint ROT_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    frustum_picture_placement dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // placements still owed by the block, oldest first
    t_out_beat placement_queue[$];
    bit        four_by_three;   // mode the block holds right now
    bit        no_idle;         // stretch with neither side pausing
    int        mismatches;
    int        frusta_sent;
    int        placements_seen;
    int        crops_seen;
    int        stall_left;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // tan of half the angle, q16, from a 16-step rotation in q16 degrees
    function automatic longint half_angle_tan(input logic [15:0] angle);
        longint z, x, y, dx, dy;
        z = longint'(angle) <<< 7;
        x = 64'sd1 <<< 28;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ROT_DEG[i];
            end else begin
                x += dx; y -= dy; z += ROT_DEG[i];
            end
        end
        if (y <= 0) return 0;
        if (x <= 0) return 64'hFF_FFFF;
        return clamp_tan((y <<< 16) / x);
    endfunction

    function automatic longint clamp_tan(input longint t);
        return (t > 64'hFF_FFFF) ? 64'hFF_FFFF : t;
    endfunction

    // num / den as q1.15, rounded half up, clipped to 0..1
    function automatic logic [15:0] to_fraction(input longint num, input longint den);
        if (num <= 0) return 16'd0;
        if (num >= den) return 16'(ONE_Q15);
        return 16'(((num <<< 16) + den) / (2 * den));
    endfunction

    function automatic t_out_beat place_picture(input t_in_beat f, input bit mode43);
        t_out_beat p;
        longint l, r, t, b, ew, eh, tan_half, tw, th;
        l  = longint'(f.eye_left) * 16;
        r  = longint'(f.eye_right) * 16;
        t  = longint'(f.eye_top) * 16;
        b  = longint'(f.eye_bottom) * 16;
        ew = r - l;
        eh = b - t;
        p = '{dest_u_low: 16'd0, dest_u_high: 16'(ONE_Q15),
              dest_v_low: 16'd0, dest_v_high: 16'(ONE_Q15),
              src_u_low: 16'd0, src_u_high: 16'(ONE_Q15),
              src_v_low: 16'd0, src_v_high: 16'(ONE_Q15), cropped: 1'b0};
        if (f.frame_width == 0 || f.frame_height == 0 ||
            f.view_angle <= ANG_MIN || f.view_angle >= ANG_MAX)
            return p;
        tan_half = half_angle_tan(f.view_angle);
        if (mode43) begin
            th = (tan_half * 3) >>> 2;
            tw = clamp_tan(th * f.frame_width / f.frame_height);
        end else begin
            tw = tan_half;
            th = clamp_tan(tw * f.frame_height / f.frame_width);
        end
        if (tw <= 0 || th <= 0 || ew <= 0 || eh <= 0)
            return p;
        // picture centred on the view axis, one to one with the eye texture
        p.dest_u_low  = to_fraction(-l - tw, ew);
        p.dest_u_high = to_fraction(-l + tw, ew);
        p.dest_v_low  = to_fraction(b - th, eh);
        p.dest_v_high = to_fraction(b + th, eh);
        // each clipped edge cuts the same share off the source
        if (-l - tw < 0) begin
            p.src_u_low = to_fraction(l + tw, 2 * tw);
            p.cropped   = 1'b1;
        end
        if (-l + tw > ew) begin
            p.src_u_high = to_fraction(tw + r, 2 * tw);
            p.cropped    = 1'b1;
        end
        if (b - th < 0) begin
            p.src_v_low = to_fraction(th - b, 2 * th);
            p.cropped   = 1'b1;
        end
        if (b + th > eh) begin
            p.src_v_high = to_fraction(th - t, 2 * th);
            p.cropped    = 1'b1;
        end
        return p;
    endfunction

    // ---------------------------------------------------------------
    // result side: random stalls and the check of every beat
    // ---------------------------------------------------------------

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d (beat %0d)",
                     what, want, got, placements_seen);
    endfunction

    function automatic void compare_placement(input t_out_beat got);
        t_out_beat want;
        if (placement_queue.size() == 0) begin
            note_mismatch("unexpected placement beat", 0, 1);
            return;
        end
        want = placement_queue.pop_front();
        if (got.dest_u_low  !== want.dest_u_low)
            note_mismatch("dest_u_low", want.dest_u_low, got.dest_u_low);
        if (got.dest_u_high !== want.dest_u_high)
            note_mismatch("dest_u_high", want.dest_u_high, got.dest_u_high);
        if (got.dest_v_low  !== want.dest_v_low)
            note_mismatch("dest_v_low", want.dest_v_low, got.dest_v_low);
        if (got.dest_v_high !== want.dest_v_high)
            note_mismatch("dest_v_high", want.dest_v_high, got.dest_v_high);
        if (got.src_u_low   !== want.src_u_low)
            note_mismatch("src_u_low", want.src_u_low, got.src_u_low);
        if (got.src_u_high  !== want.src_u_high)
            note_mismatch("src_u_high", want.src_u_high, got.src_u_high);
        if (got.src_v_low   !== want.src_v_low)
            note_mismatch("src_v_low", want.src_v_low, got.src_v_low);
        if (got.src_v_high  !== want.src_v_high)
            note_mismatch("src_v_high", want.src_v_high, got.src_v_high);
        if (got.cropped     !== want.cropped)
            note_mismatch("cropped", want.cropped, got.cropped);
        if (want.cropped) crops_seen++;
    endfunction

    // one assignment of out_ready per edge; a fresh stall is drawn after each beat
    always @(posedge i_clk) begin
        logic next_ready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                compare_placement(out_beat);
                placements_seen++;
                stall_left = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        out_ready <= next_ready;
    end

    // ---------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------

    // valid stays up between back-to-back beats, it only drops for a gap
    task automatic send_frustum(input t_in_beat f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= f;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        placement_queue.push_back(place_picture(f, four_by_three));
        frusta_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (placement_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // mode change only with the pipe empty
    task automatic write_mode(input bit mode43);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode43;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid     <= 1'b0;
        four_by_three = mode43;
    endtask

    function automatic t_in_beat make_frustum(input int l, input int r, input int t,
                                              input int b, input int ang, input int w,
                                              input int h);
        t_in_beat f;
        f.eye_left     = 16'(l);
        f.eye_right    = 16'(r);
        f.eye_top      = 16'(t);
        f.eye_bottom   = 16'(b);
        f.view_angle   = 16'(ang);
        f.frame_width  = 16'(w);
        f.frame_height = 16'(h);
        return f;
    endfunction

    // frames, angles and eye frusta outside the usable range give the full-texture default, as does a zero tangent
    task automatic test_degenerate_inputs();
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, 90 * 256, 0, 1080));
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, 90 * 256, 1920, 0));
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, ANG_MIN, 1920, 1080));
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, ANG_MAX, 1920, 1080));
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, 0, 1920, 1080));
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, 46079, 1920, 1080));
        // eye frustum with no width or no height
        send_frustum(make_frustum(4096, 4096, -4096, 4096, 90 * 256, 1920, 1080));
        send_frustum(make_frustum(-4096, 4096, 4096, -4096, 90 * 256, 1920, 1080));
        // with the horizontal angle, the aspect step rounds a picture tangent down to zero
        send_frustum(make_frustum(-4096, 4096, -4096, 4096, ANG_MIN + 1, 65535, 1));
    endtask

    // ordinary placements, crops on each edge, field extremes, aspect saturation
    task automatic test_placements();
        send_frustum(make_frustum(-5000, 5000, -5000, 5000, 60 * 256, 1920, 1080));
        send_frustum(make_frustum(-2000, 6000, -3000, 5000, 110 * 256, 1280, 1024));
        send_frustum(make_frustum(-32768, 32767, -32768, 32767, ANG_MAX - 1, 65535, 65535));
        send_frustum(make_frustum(-1, 1, -1, 1, ANG_MIN + 1, 1, 1));
        send_frustum(make_frustum(-32768, 32767, -32768, 32767, 90 * 256, 1, 65535));
        send_frustum(make_frustum(1000, 3000, 500, 2000, 120 * 256, 800, 600));
        send_frustum(make_frustum(-3000, -1000, -2000, -500, 150 * 256, 640, 480));
        send_frustum(make_frustum(-4096, 100, -100, 4096, 178 * 256, 1000, 3000));
        send_frustum(make_frustum(-6000, 4000, -4500, 4000, 95 * 256, 1440, 900));
    endtask

    function automatic t_in_beat random_frustum();
        t_in_beat f;
        int lo, hi;
        f = t_in_beat'(112'({$urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(0, 9) < 8) begin
            // well formed: eye straddles or sits near the axis, usable angle and frame
            lo = $urandom_range(1, 12000);
            hi = $urandom_range(1, 12000);
            f.eye_left     = $urandom_range(0, 7) == 0 ? 16'(lo) : -16'(lo);
            f.eye_right    = 16'(hi) + ($urandom_range(0, 7) == 0 ? f.eye_left : 16'd0);
            lo = $urandom_range(1, 12000);
            hi = $urandom_range(1, 12000);
            f.eye_top      = -16'(lo);
            f.eye_bottom   = 16'(hi);
            f.view_angle   = 16'($urandom_range(ANG_MIN + 1, ANG_MAX - 1));
            f.frame_width  = 16'($urandom_range(1, $urandom_range(0, 3) == 0 ? 65535 : 4096));
            f.frame_height = 16'($urandom_range(1, $urandom_range(0, 3) == 0 ? 65535 : 4096));
        end
        return f;
    endfunction

    task automatic test_random_frusta(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_frustum(random_frustum());
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        in_valid        <= 1'b0;
        in_beat         <= '0;
        cfg_valid       <= 1'b0;
        cfg_data        <= 1'b0;
        four_by_three   = 1'b0;
        no_idle         = 1'b0;
        mismatches      = 0;
        frusta_sent     = 0;
        placements_seen = 0;
        crops_seen      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // horizontal angle out of reset
        test_degenerate_inputs();
        test_placements();
        write_mode(1'b1);
        test_degenerate_inputs();
        test_placements();
        test_random_frusta(150);
        write_mode(1'b0);
        test_random_frusta(150);
        write_mode(1'b1);
        test_random_frusta(50);
        write_mode(1'b0);
        test_random_frusta(50);
        wait_drained();

        if (placement_queue.size() != 0)
            note_mismatch("placements never delivered", 0, placement_queue.size());
        $display("covered %0d frusta in both angle modes, %0d placements checked, %0d cropped",
                 frusta_sent, placements_seen, crops_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("timeout with %0d placements outstanding", placement_queue.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
